FILE: src/ret_pkg.sv
// ret_pkg: shared types, codes and constants for the rain episode tracker.
// No dependencies; imported by ret_core and rain_episode_tracker.
package ret_pkg;

    localparam int TOTAL_WIDTH_DEF = 24;

    localparam logic [7:0]  MM_PER_TIP_RESET = 8'd20;
    localparam logic [31:0] TIMEOUT_RESET    = 32'd3600000;

    // ceil(2^34 / 5): exact floor(y / 5) for any 32-bit y via (y * M) >> 34
    localparam logic [31:0] DIV5_MUL = 32'hCCCC_CCCD;

    typedef enum logic {
        OP_REPORT = 1'b0,
        OP_TICK   = 1'b1
    } t_op;

    typedef enum logic {
        CFG_MM_PER_TIP = 1'b0,
        CFG_TIMEOUT    = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic        op;
        logic [6:0]  tip_count;
        logic [31:0] now_ms;
        logic [15:0] date_stamp;
        logic [16:0] time_of_day;
    } t_item;

    typedef struct packed {
        logic [7:0]  mm_per_tip_hundredths;
        logic [31:0] episode_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic        tip_occurred;
        logic [6:0]  tip_delta;
        logic        episode_started;
        logic        episode_ended;
        logic        episode_active;
        logic [23:0] episode_total;
        logic [23:0] daily_total;
        logic [20:0] ended_total_tenths;
        logic [15:0] episode_start_date;
        logic [16:0] episode_start_time;
        logic        last_event_valid;
    } t_result;

    // floor(x / 10) for x below 2^33: halve, then divide by 5 by reciprocal
    function automatic logic [29:0] div10(input logic [32:0] x);
        logic [31:0] half;
        logic [63:0] prod;
        half = x[32:1];
        prod = 64'(half) * 64'(DIV5_MUL);
        return prod[63:34];
    endfunction

endpackage

FILE: src/ret_core.sv
// ret_core: tracker state registers and the per-word update logic.
// Depends on ret_pkg; instantiated by rain_episode_tracker.
module ret_core
    import ret_pkg::*;
#(
    parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic                   r_baseline_set,   n_baseline_set;
    logic [6:0]             r_previous_count, n_previous_count;
    logic                   r_episode_open,   n_episode_open;
    logic [31:0]            r_last_tip_time,  n_last_tip_time;
    logic [TOTAL_WIDTH-1:0] r_episode_sum,    n_episode_sum;
    logic [TOTAL_WIDTH-1:0] r_daily_sum,      n_daily_sum;
    logic [15:0]            r_daily_date_ref, n_daily_date_ref;
    logic                   r_daily_ref_valid, n_daily_ref_valid;
    logic [15:0]            r_start_date,     n_start_date;
    logic [16:0]            r_start_time,     n_start_time;
    logic                   r_event_seen,     n_event_seen;

    always_comb begin
        logic [6:0]             delta;
        logic [14:0]            add;
        logic [31:0]            elapsed;
        logic [29:0]            tenths;
        logic                   tip;
        logic                   started;
        logic                   ended;
        logic                   new_day;
        logic [TOTAL_WIDTH-1:0] ep_base;
        logic [TOTAL_WIDTH-1:0] day_base;
        logic [TOTAL_WIDTH:0]   ep_s;
        logic [TOTAL_WIDTH:0]   day_s;

        n_baseline_set    = r_baseline_set;
        n_previous_count  = r_previous_count;
        n_episode_open    = r_episode_open;
        n_last_tip_time   = r_last_tip_time;
        n_episode_sum     = r_episode_sum;
        n_daily_sum       = r_daily_sum;
        n_daily_date_ref  = r_daily_date_ref;
        n_daily_ref_valid = r_daily_ref_valid;
        n_start_date      = r_start_date;
        n_start_time      = r_start_time;
        n_event_seen      = r_event_seen;

        delta   = i_item.tip_count - r_previous_count;
        add     = {8'd0, delta} * {7'd0, i_cfg.mm_per_tip_hundredths};
        elapsed = i_item.now_ms - r_last_tip_time;
        tenths  = div10(33'(r_episode_sum) + 33'd5);

        tip     = (i_item.op == OP_REPORT) && r_baseline_set
                  && (i_item.tip_count != r_previous_count);
        started = tip && !r_episode_open;
        ended   = (i_item.op == OP_TICK) && r_episode_open
                  && (elapsed >= i_cfg.episode_timeout_ms);
        new_day = !r_daily_ref_valid || (r_daily_date_ref != i_item.date_stamp);

        ep_base  = started ? '0 : r_episode_sum;
        day_base = new_day ? '0 : r_daily_sum;
        ep_s     = {1'b0, ep_base} + (TOTAL_WIDTH+1)'(add);
        day_s    = {1'b0, day_base} + (TOTAL_WIDTH+1)'(add);

        if (i_item.op == OP_REPORT && !r_baseline_set) begin
            n_baseline_set   = 1'b1;
            n_previous_count = i_item.tip_count;
        end
        if (tip) begin
            n_previous_count  = i_item.tip_count;
            n_episode_open    = 1'b1;
            n_episode_sum     = ep_s[TOTAL_WIDTH] ? '1 : ep_s[TOTAL_WIDTH-1:0];
            n_daily_sum       = day_s[TOTAL_WIDTH] ? '1 : day_s[TOTAL_WIDTH-1:0];
            n_daily_date_ref  = i_item.date_stamp;
            n_daily_ref_valid = 1'b1;
            n_last_tip_time   = i_item.now_ms;
            n_event_seen      = 1'b1;
        end
        if (started) begin
            n_start_date = i_item.date_stamp;
            n_start_time = i_item.time_of_day;
        end
        if (ended) begin
            n_episode_open = 1'b0;
        end

        o_result.tip_occurred       = tip;
        o_result.tip_delta          = tip ? delta : 7'd0;
        o_result.episode_started    = started;
        o_result.episode_ended      = ended;
        o_result.episode_active     = n_episode_open;
        o_result.episode_total      = 24'(32'(n_episode_sum));
        o_result.daily_total        = 24'(32'(n_daily_sum));
        o_result.ended_total_tenths = ended ? tenths[20:0] : 21'd0;
        o_result.episode_start_date = n_start_date;
        o_result.episode_start_time = n_start_time;
        o_result.last_event_valid   = n_event_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline_set    <= 1'b0;
            r_previous_count  <= '0;
            r_episode_open    <= 1'b0;
            r_last_tip_time   <= '0;
            r_episode_sum     <= '0;
            r_daily_sum       <= '0;
            r_daily_date_ref  <= '0;
            r_daily_ref_valid <= 1'b0;
            r_start_date      <= '0;
            r_start_time      <= '0;
            r_event_seen      <= 1'b0;
        end else if (i_advance) begin
            r_baseline_set    <= n_baseline_set;
            r_previous_count  <= n_previous_count;
            r_episode_open    <= n_episode_open;
            r_last_tip_time   <= n_last_tip_time;
            r_episode_sum     <= n_episode_sum;
            r_daily_sum       <= n_daily_sum;
            r_daily_date_ref  <= n_daily_date_ref;
            r_daily_ref_valid <= n_daily_ref_valid;
            r_start_date      <= n_start_date;
            r_start_time      <= n_start_time;
            r_event_seen      <= n_event_seen;
        end
    end

endmodule

FILE: src/rain_episode_tracker.sv
// rain_episode_tracker: top level with input word register, result register
// and configuration registers. Depends on ret_pkg and ret_core.
//
// Usage: input words (op, tip_count, now_ms, date_stamp, time_of_day) arrive on
// i_in_valid / o_in_stall; each word yields exactly one result word on
// o_out_valid / i_out_stall. A word is taken when valid is high and stall low.
// The update logic runs combinationally between the input register and the result
// register; a taken word moves into the result register, and o_out_valid rises, once
// the result register is free or the receiver does not stall.
// Throughput is one word per cycle unless the receiver stalls; the tracker state is
// read and written as a word moves from the input register to the result register.
// When the receiver stalls, the result register holds and the input register
// still fills, so one more word is taken before o_in_stall rises.
// Configuration: i_cfg_valid with i_cfg_index (0 mm per tip, 1 timeout ms) and
// i_cfg_data; o_cfg_ready is always high. Write only while the block is idle.
// Reset (i_rst_n low, synchronous) clears all tracker state, empties both pipeline
// registers and sets the configuration registers to 20 and 3600000.
module rain_episode_tracker
    import ret_pkg::*;
#(
    parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [6:0]  i_tip_count,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_date_stamp,
    input  logic [16:0] i_time_of_day,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_tip_occurred,
    output logic [6:0]  o_tip_delta,
    output logic        o_episode_started,
    output logic        o_episode_ended,
    output logic        o_episode_active,
    output logic [23:0] o_episode_total,
    output logic [23:0] o_daily_total,
    output logic [20:0] o_ended_total_tenths,
    output logic [15:0] o_episode_start_date,
    output logic [16:0] o_episode_start_time,
    output logic        o_last_event_valid,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_cfg    r_cfg;
    t_result core_result;
    logic    advance;
    logic    in_take;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    ret_core #(
        .TOTAL_WIDTH(TOTAL_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(advance),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in.op          <= i_op;
            r_in.tip_count   <= i_tip_count;
            r_in.now_ms      <= i_now_ms;
            r_in.date_stamp  <= i_date_stamp;
            r_in.time_of_day <= i_time_of_day;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mm_per_tip_hundredths <= MM_PER_TIP_RESET;
            r_cfg.episode_timeout_ms    <= TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MM_PER_TIP: r_cfg.mm_per_tip_hundredths <= i_cfg_data[7:0];
                CFG_TIMEOUT:    r_cfg.episode_timeout_ms    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_tip_occurred       = r_out.tip_occurred;
    assign o_tip_delta          = r_out.tip_delta;
    assign o_episode_started    = r_out.episode_started;
    assign o_episode_ended      = r_out.episode_ended;
    assign o_episode_active     = r_out.episode_active;
    assign o_episode_total      = r_out.episode_total;
    assign o_daily_total        = r_out.daily_total;
    assign o_ended_total_tenths = r_out.ended_total_tenths;
    assign o_episode_start_date = r_out.episode_start_date;
    assign o_episode_start_time = r_out.episode_start_time;
    assign o_last_event_valid   = r_out.last_event_valid;

    a_ended_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.episode_ended |-> !r_out.episode_active
            && !r_out.tip_occurred)
        else $error("closed episode still active");

    a_started_on_tip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.episode_started |-> r_out.tip_occurred
            && r_out.episode_active && r_out.last_event_valid)
        else $error("episode opened without a tip");

    a_tip_delta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.tip_occurred |-> r_out.tip_delta != 7'd0)
        else $error("tip with zero delta");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && i_out_stall |=> r_in_valid && $stable(r_in))
        else $error("pending word lost under stall");

endmodule

FILE: sim/tb_top.sv
// tb_top: self-checking bench for rain_episode_tracker; depends on ret_pkg and the RTL.
// Drives gauge report and tick words with random bursts and output stalls, predicts each
// result word in-bench and compares it with the block's output in order.
module tb_top;
    import ret_pkg::*;

    typedef struct {
        bit          baseline;
        logic [6:0]  prev_count;
        bit          open;
        logic [31:0] last_tip_ms;
        logic [23:0] episode_sum;
        logic [23:0] day_sum;
        logic [15:0] day_ref;
        bit          day_ref_ok;
        logic [15:0] start_date;
        logic [16:0] start_time;
        bit          tip_seen;
    } t_gauge_state;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_op = 1'b0;
    logic [6:0]  i_tip_count = '0;
    logic [31:0] i_now_ms = '0;
    logic [15:0] i_date_stamp = '0;
    logic [16:0] i_time_of_day = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_tip_occurred;
    logic [6:0]  o_tip_delta;
    logic        o_episode_started;
    logic        o_episode_ended;
    logic        o_episode_active;
    logic [23:0] o_episode_total;
    logic [23:0] o_daily_total;
    logic [20:0] o_ended_total_tenths;
    logic [15:0] o_episode_start_date;
    logic [16:0] o_episode_start_time;
    logic        o_last_event_valid;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_MM_PER_TIP;
    logic [31:0] i_cfg_data = '0;

    t_gauge_state gauge = '{default: '0};
    logic [7:0]   mm_per_tip = MM_PER_TIP_RESET;
    logic [31:0]  timeout_ms = TIMEOUT_RESET;
    t_result      gauge_results_due[$];
    int           mismatch_count = 0;
    int           burst_left = 0;
    int           gap_max = 0;
    int           stall_pct = 0;
    int           stall_run = 0;
    bit           stall_hold = 1'b0;

    rain_episode_tracker u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_op                 (i_op),
        .i_tip_count          (i_tip_count),
        .i_now_ms             (i_now_ms),
        .i_date_stamp         (i_date_stamp),
        .i_time_of_day        (i_time_of_day),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_tip_occurred       (o_tip_occurred),
        .o_tip_delta          (o_tip_delta),
        .o_episode_started    (o_episode_started),
        .o_episode_ended      (o_episode_ended),
        .o_episode_active     (o_episode_active),
        .o_episode_total      (o_episode_total),
        .o_daily_total        (o_daily_total),
        .o_ended_total_tenths (o_ended_total_tenths),
        .o_episode_start_date (o_episode_start_date),
        .o_episode_start_time (o_episode_start_time),
        .o_last_event_valid   (o_last_event_valid),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [23:0] sat_total(input logic [23:0] a, input logic [14:0] b);
        logic [24:0] s;
        s = {1'b0, a} + 25'(b);
        return s[24] ? 24'hFF_FFFF : s[23:0];
    endfunction

    // advances the gauge state by one word and returns the result word it yields
    function automatic t_result track_rain(input t_item w);
        t_result     r;
        logic [14:0] rain;
        logic [31:0] elapsed;
        r = '0;
        if (w.op == OP_REPORT) begin
            if (!gauge.baseline) begin
                gauge.baseline = 1'b1;
                gauge.prev_count = w.tip_count;
            end else if (w.tip_count != gauge.prev_count) begin
                r.tip_occurred = 1'b1;
                r.tip_delta = w.tip_count - gauge.prev_count;
                gauge.prev_count = w.tip_count;
                if (!gauge.open) begin
                    gauge.open = 1'b1;
                    r.episode_started = 1'b1;
                    gauge.episode_sum = '0;
                    gauge.start_date = w.date_stamp;
                    gauge.start_time = w.time_of_day;
                end
                rain = 15'(r.tip_delta) * 15'(mm_per_tip);
                gauge.episode_sum = sat_total(gauge.episode_sum, rain);
                gauge.last_tip_ms = w.now_ms;
                gauge.tip_seen = 1'b1;
                if (!gauge.day_ref_ok || gauge.day_ref != w.date_stamp) begin
                    gauge.day_sum = '0;
                    gauge.day_ref = w.date_stamp;
                    gauge.day_ref_ok = 1'b1;
                end
                gauge.day_sum = sat_total(gauge.day_sum, rain);
            end
        end else begin
            elapsed = w.now_ms - gauge.last_tip_ms;
            if (gauge.open && elapsed >= timeout_ms) begin
                r.episode_ended = 1'b1;
                r.ended_total_tenths = 21'((25'(gauge.episode_sum) + 25'd5) / 25'd10);
                gauge.open = 1'b0;
            end
        end
        r.episode_active = gauge.open;
        r.episode_total = gauge.episode_sum;
        r.daily_total = gauge.day_sum;
        r.episode_start_date = gauge.start_date;
        r.episode_start_time = gauge.start_time;
        r.last_event_valid = gauge.tip_seen;
        return r;
    endfunction

    function automatic string fmt_result(input t_result r);
        return $sformatf({"tip=%0d delta=%0d start=%0d end=%0d active=%0d ep=%0d day=%0d ",
                          "tenths=%0d sdate=%0d stime=%0d seen=%0d"},
                         r.tip_occurred, r.tip_delta, r.episode_started, r.episode_ended,
                         r.episode_active, r.episode_total, r.daily_total,
                         r.ended_total_tenths, r.episode_start_date, r.episode_start_time,
                         r.last_event_valid);
    endfunction

    // receiver stall runs
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_hold = ($urandom_range(99) < stall_pct);
            stall_run = $urandom_range(1, 8);
        end
        stall_run = stall_run - 1;
        i_out_stall <= stall_hold && i_rst_n;
    end

    always @(posedge i_clk) begin
        t_result seen_word;
        t_result due_word;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_word = {o_tip_occurred, o_tip_delta, o_episode_started, o_episode_ended,
                         o_episode_active, o_episode_total, o_daily_total,
                         o_ended_total_tenths, o_episode_start_date, o_episode_start_time,
                         o_last_event_valid};
            if (gauge_results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word: %s", fmt_result(seen_word));
            end else begin
                due_word = gauge_results_due.pop_front();
                if (seen_word !== due_word) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected %s", fmt_result(due_word));
                        $display("          actual   %s", fmt_result(seen_word));
                    end
                end
            end
        end
    end

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_word(input t_op op, input logic [6:0] count, input logic [31:0] now,
                             input logic [15:0] date, input logic [16:0] tod);
        t_item w;
        w.op = op;
        w.tip_count = count;
        w.now_ms = now;
        w.date_stamp = date;
        w.time_of_day = tod;
        i_in_valid <= 1'b1;
        i_op <= w.op;
        i_tip_count <= count;
        i_now_ms <= now;
        i_date_stamp <= date;
        i_time_of_day <= tod;
        do @(posedge i_clk); while (o_in_stall);
        gauge_results_due.push_back(track_rain(w));
        pace_sender();
    endtask

    // pause until every result word is back, then let the pipeline settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (gauge_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] mm, input logic [31:0] timeout);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_MM_PER_TIP;
        i_cfg_data <= 32'(mm);
        do @(posedge i_clk); while (!o_cfg_ready);
        mm_per_tip = mm;
        i_cfg_index <= CFG_TIMEOUT;
        i_cfg_data <= timeout;
        do @(posedge i_clk); while (!o_cfg_ready);
        timeout_ms = timeout;
        i_cfg_valid <= 1'b0;
    endtask

    // baseline, unchanged count, wrap, timeout with reset settings
    task automatic test_reset_settings();
        gap_max = 2;
        stall_pct = 30;
        send_word(OP_REPORT, 7'd100, 32'd1000, 16'd100, 17'd3600);
        send_word(OP_TICK, 7'd55, 32'd2000, 16'd100, 17'd3601);
        send_word(OP_REPORT, 7'd100, 32'd3000, 16'd100, 17'd3602);
        send_word(OP_REPORT, 7'd101, 32'd4000, 16'd100, 17'd3700);
        send_word(OP_REPORT, 7'd5, 32'd5000, 16'd100, 17'd3800);
        send_word(OP_REPORT, 7'd4, 32'd6000, 16'd100, 17'd3900);
        send_word(OP_TICK, 7'd0, 32'd3605999, 16'd100, 17'd7000);
        send_word(OP_REPORT, 7'd10, 32'd4006000, 16'd100, 17'd8000);
        send_word(OP_TICK, 7'd127, 32'd7606000, 16'd100, 17'd9000);
        send_word(OP_TICK, 7'd127, 32'd7606001, 16'd100, 17'd9001);
    endtask

    // register extremes, zero registers, wrapped time, date and time-of-day extremes
    task automatic test_config_extremes();
        set_config(8'd255, 32'd1);
        send_word(OP_REPORT, 7'd127, 32'hFFFF_FF00, 16'hFFFF, 17'h1FFFF);
        send_word(OP_TICK, 7'd0, 32'hFFFF_FF00, 16'hFFFF, 17'h1FFFF);
        send_word(OP_TICK, 7'd0, 32'hFFFF_FF01, 16'hFFFF, 17'h1FFFF);
        set_config(8'd0, 32'd0);
        send_word(OP_REPORT, 7'd0, 32'hFFFF_FFFF, 16'd0, 17'd0);
        send_word(OP_TICK, 7'd0, 32'hFFFF_FFFF, 16'd0, 17'd0);
        set_config(8'd1, 32'hFFFF_FFFF);
        send_word(OP_REPORT, 7'd64, 32'h0000_0100, 16'd0, 17'd86399);
        send_word(OP_TICK, 7'd0, 32'h0000_00FE, 16'd0, 17'd86399);
        send_word(OP_TICK, 7'd0, 32'h0000_00FF, 16'd0, 17'd86399);
    endtask

    // long episode of maximum deltas until both totals saturate
    task automatic test_saturation();
        logic [6:0]  count;
        logic [31:0] now;
        count = 7'd64;
        now = 32'd5000;
        set_config(8'd255, 32'hFFFF_FFFF);
        gap_max = 1;
        stall_pct = 20;
        repeat (530) begin
            count = count - 7'd1;
            now = now + 32'd1;
            send_word(OP_REPORT, count, now, 16'd4242, 17'd43200);
        end
        send_word(OP_TICK, 7'd0, now - 32'd1, 16'd4242, 17'd43200);
        send_word(OP_TICK, 7'd0, now + 32'hFFFF_FFFF, 16'd4242, 17'd43200);
    endtask

    task automatic test_random_traffic(input int phases, input int words_per_phase);
        logic [6:0]  count;
        logic [31:0] now;
        logic [15:0] date;
        logic [16:0] tod;
        logic [7:0]  mm;
        logic [31:0] timeout;
        int          step_max;
        int          pick;
        for (int p = 0; p < phases; p++) begin
            case ($urandom_range(3))
                0: mm = 8'd1;
                1: mm = 8'd255;
                default: mm = 8'($urandom_range(1, 255));
            endcase
            case ($urandom_range(5))
                0: timeout = 32'd1;
                1: timeout = 32'hFFFF_FFFF;
                2: timeout = $urandom;
                default: timeout = $urandom_range(50, 3000);
            endcase
            set_config(mm, timeout);
            gap_max = (p == 0) ? 0 : $urandom_range(0, 8);
            stall_pct = (p == 0) ? 0 : $urandom_range(10, 75);
            step_max = $urandom_range(10, 1500);
            count = 7'($urandom_range(127));
            now = $urandom;
            date = 16'($urandom_range(65535));
            repeat (words_per_phase) begin
                pick = $urandom_range(99);
                now = (pick == 99) ? $urandom : now + 32'($urandom_range(0, step_max));
                if (pick < 8)
                    date = date + 16'd1;
                tod = ($urandom_range(19) == 0) ? 17'($urandom_range(131071))
                                                 : 17'($urandom_range(86399));
                if (pick < 60) begin
                    count = count + (($urandom_range(9) < 8) ? 7'($urandom_range(1, 4))
                                                             : 7'($urandom_range(1, 127)));
                    send_word(OP_REPORT, count, now, date, tod);
                end else if (pick < 68) begin
                    send_word(OP_REPORT, count, now, date, tod);
                end else if (pick < 73) begin
                    count = 7'($urandom_range(127));
                    send_word(OP_REPORT, count, now, date, tod);
                end else begin
                    send_word(OP_TICK, 7'($urandom_range(127)), now, date, tod);
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_settings();
        test_config_extremes();
        test_saturation();
        test_random_traffic(3, 20);
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && gauge_results_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
